>>> rtl/core/fenced_report_scoreboard_top_assert.svh
// assertion macros for the fenced report scoreboard
`ifndef FENCED_REPORT_SCOREBOARD_TOP_ASSERT_SVH
`define FENCED_REPORT_SCOREBOARD_TOP_ASSERT_SVH

// property that holds at every edge out of reset
`define FRS_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// property with a trigger and a consequence
`define FRS_ASSERT_IMPLY(lbl, clk, rst, trig, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

`endif

>>> rtl/core/fenrs_pkg.sv
// shared types and constants of the fenced report scoreboard
package fenrs_pkg;

   localparam int QueueDepth  = 16;
   localparam int IdxW        = $clog2(QueueDepth);
   localparam int CntW        = $clog2(QueueDepth + 1);
   localparam int WindowBytes = 16;

   localparam logic [2:0] ACT_ENQUEUE  = 3'd0;
   localparam logic [2:0] ACT_CLEAR    = 3'd1;
   localparam logic [2:0] ACT_COMPLETE = 3'd2;
   localparam logic [2:0] ACT_CONSUME  = 3'd3;
   localparam logic [2:0] ACT_RESET    = 3'd4;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DISABLED = 2'd1,
      STATUS_NO_FENCE = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_SCAN = 2'd1,
      S_EMIT = 2'd2
   } state_type;

   typedef struct packed {
      logic [31:0] address;
      logic [63:0] fence;
      logic [31:0] sequence_num;
      logic [31:0] generation;
   } entry_type;

   typedef struct packed {
      logic start;
      logic enable;
      logic valid;
   } scan_ctl_type;

   typedef struct packed {
      logic [CntW-1:0] overlaps;
      logic [63:0]     required;
      logic [CntW-1:0] pops;
   } scan_res_type;

endpackage

>>> rtl/core/fenrs_cell.sv
// one cell of the report ring, passes its entry to the neighbor on shift
module fenrs_cell (
   input  logic                clock,
   input  logic                shift,
   input  logic                load,
   input  fenrs_pkg::entry_type load_data,
   input  fenrs_pkg::entry_type nbr_data,
   output fenrs_pkg::entry_type data
);

   fenrs_pkg::entry_type data_ff;
   fenrs_pkg::entry_type data_in;

   always_comb begin
      data_in = data_ff;
      if (shift) begin
         data_in = load ? load_data : nbr_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

>>> rtl/core/fenrs_scan.sv
// compare unit at the head of the ring, accumulates over one rotation
module fenrs_scan (
   input  logic                   clock,
   input  logic                   reset,
   input  fenrs_pkg::scan_ctl_type ctl,
   input  fenrs_pkg::entry_type    head,
   input  logic [31:0]             win_address,
   input  logic [31:0]             win_size,
   input  logic [63:0]             done_fence,
   output fenrs_pkg::scan_res_type res
);

   fenrs_pkg::scan_res_type res_ff;
   fenrs_pkg::scan_res_type res_in;
   logic run_ff;
   logic run_in;
   logic [32:0] head_end;
   logic [32:0] new_end;
   logic [32:0] win_end;
   logic ovl_fixed;
   logic ovl_win;

   always_comb begin
      head_end  = {1'b0, head.address} + 33'(fenrs_pkg::WindowBytes);
      new_end   = {1'b0, win_address} + 33'(fenrs_pkg::WindowBytes);
      win_end   = {1'b0, win_address} + {1'b0, win_size};
      ovl_fixed = ({1'b0, head.address} < new_end) && ({1'b0, win_address} < head_end);
      ovl_win   = (win_size != 32'd0) && ({1'b0, head.address} < win_end)
                  && ({1'b0, win_address} < head_end);
   end

   always_comb begin
      res_in = res_ff;
      run_in = run_ff;
      if (ctl.start) begin
         res_in = '0;
         run_in = 1'b1;
      end else if (ctl.enable) begin
         if (ctl.valid && ovl_fixed) begin
            res_in.overlaps = res_ff.overlaps + 1'b1;
         end
         if (ctl.valid && ovl_win && (head.fence > res_ff.required)) begin
            res_in.required = head.fence;
         end
         if (ctl.valid && run_ff && (head.fence <= done_fence)) begin
            res_in.pops = res_ff.pops + 1'b1;
         end else begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
         run_ff <= 1'b0;
      end else begin
         res_ff <= res_in;
         run_ff <= run_in;
      end
   end

   // includes the compare of the current step
   assign res = res_in;

endmodule

>>> rtl/core/fenced_report_scoreboard_top.sv
// fenced report scoreboard: top level with control and ring of cells
//
// usage:
//   req_* carries one action word, accepted when req_valid is high and
//   req_stall low. rsp_* returns result words, accepted when rsp_valid is
//   high and rsp_stall low; rsp_last marks the final word of an action.
//   csr_* writes the enable register, always ready; write only when idle.
// timing:
//   every action rotates the 16-cell ring once past the head compare unit,
//   and its first result word is loaded into the output register after the
//   rotation. further words of a complete follow one per cycle while
//   rsp_stall is low. one action is in work at a time; req_stall is high
//   from accept until its last word is loaded into the output register.
// reset: synchronous, empties the queue, sequence and generation start at
//   one, enable clears. a stalled result holds the output register and the
//   ring waits.
module fenced_report_scoreboard_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [31:0] req_report_address,
   input  logic [31:0] req_read_size,
   input  logic [63:0] req_record_fence,
   input  logic [63:0] req_submit_fence,
   input  logic [63:0] req_done_fence,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_published_sequence,
   output logic [31:0] rsp_published_address,
   output logic [63:0] rsp_published_fence,
   output logic [31:0] rsp_published_generation,
   output logic [63:0] rsp_required_fence,
   output logic [4:0]  rsp_overlap_count,
   output logic [4:0]  rsp_result_count,
   output logic [4:0]  rsp_pending_count,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_enable
);

   `include "fenced_report_scoreboard_top_assert.svh"

   localparam int Depth = fenrs_pkg::QueueDepth;
   localparam int IdxW  = fenrs_pkg::IdxW;
   localparam int CntW  = fenrs_pkg::CntW;

   fenrs_pkg::state_type state_ff, state_in;
   logic [IdxW-1:0] step_ff, step_in;
   logic [2:0]  action_ff, action_in;
   logic [31:0] addr_ff, addr_in;
   logic [31:0] size_ff, size_in;
   logic [63:0] rfence_ff, rfence_in;
   logic [63:0] dfence_ff, dfence_in;
   fenrs_pkg::status_type status_ff, status_in;
   logic enq_ok_ff, enq_ok_in;
   logic multi_ff, multi_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] left_ff, left_in;
   logic [CntW-1:0] rcnt_ff, rcnt_in;
   logic [31:0] seq_ff, seq_in;
   logic [31:0] gen_ff, gen_in;
   logic enable_ff, enable_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0]  status_o_ff, status_o_in;
   logic [31:0] pseq_ff, pseq_in;
   logic [31:0] paddr_ff, paddr_in;
   logic [63:0] pfence_ff, pfence_in;
   logic [31:0] pgen_ff, pgen_in;
   logic [63:0] reqf_ff, reqf_in;
   logic [CntW-1:0] ovl_ff, ovl_in;
   logic [CntW-1:0] rc_ff, rc_in;
   logic [CntW-1:0] pend_ff, pend_in;
   logic last_ff, last_in;

   logic accept;
   logic out_free;
   logic shift;
   logic insert;
   logic out_load;
   logic scan_end;
   fenrs_pkg::scan_ctl_type scan_ctl;
   fenrs_pkg::scan_res_type scan_res;
   fenrs_pkg::entry_type cell_q [Depth];
   fenrs_pkg::entry_type new_entry;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign scan_end = (state_ff == fenrs_pkg::S_SCAN) && (step_ff == IdxW'(Depth - 1));
   assign csr_ready = 1'b1;

   assign new_entry.address      = addr_ff;
   assign new_entry.fence        = rfence_ff;
   assign new_entry.sequence_num = seq_ff;
   assign new_entry.generation   = gen_ff;

   for (genvar i = 0; i < Depth; i++) begin : g_cell
      fenrs_cell u_cell (
         .clock     (clock),
         .shift     (shift),
         .load      ((i == Depth - 1) ? insert : 1'b0),
         .load_data (new_entry),
         .nbr_data  (cell_q[(i + 1) % Depth]),
         .data      (cell_q[i])
      );
   end

   assign scan_ctl.start  = accept;
   assign scan_ctl.enable = (state_ff == fenrs_pkg::S_SCAN);
   assign scan_ctl.valid  = {1'b0, step_ff} < count_ff;

   fenrs_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctl         (scan_ctl),
      .head        (cell_q[0]),
      .win_address (addr_ff),
      .win_size    (size_ff),
      .done_fence  (dfence_ff),
      .res         (scan_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fenrs_pkg::S_IDLE: if (accept) state_in = fenrs_pkg::S_SCAN;
         fenrs_pkg::S_SCAN: if (scan_end) state_in = fenrs_pkg::S_EMIT;
         fenrs_pkg::S_EMIT: begin
            if (out_free && (!multi_ff || left_ff == CntW'(1))) begin
               state_in = fenrs_pkg::S_IDLE;
            end
         end
         default: state_in = fenrs_pkg::S_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall = 1'b1;
      shift     = 1'b0;
      insert    = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         fenrs_pkg::S_IDLE: req_stall = 1'b0;
         fenrs_pkg::S_SCAN: begin
            shift  = 1'b1;
            insert = enq_ok_ff && ({1'b0, step_ff} == count_ff);
         end
         fenrs_pkg::S_EMIT: begin
            out_load = out_free;
            shift    = out_free && multi_ff;
         end
         default: req_stall = 1'b1;
      endcase
   end

   // datapath
   always_comb begin
      step_in   = step_ff;
      action_in = action_ff;
      addr_in   = addr_ff;
      size_in   = size_ff;
      rfence_in = rfence_ff;
      dfence_in = dfence_ff;
      status_in = status_ff;
      enq_ok_in = enq_ok_ff;
      multi_in  = multi_ff;
      count_in  = count_ff;
      left_in   = left_ff;
      rcnt_in   = rcnt_ff;
      seq_in    = seq_ff;
      gen_in    = gen_ff;
      enable_in = enable_ff;
      if (csr_valid && csr_ready) enable_in = csr_enable;
      if (accept) begin
         step_in   = '0;
         action_in = req_action;
         addr_in   = req_report_address;
         size_in   = req_read_size;
         rfence_in = req_record_fence;
         dfence_in = req_done_fence;
         multi_in  = 1'b0;
         enq_ok_in = 1'b0;
         status_in = fenrs_pkg::STATUS_OK;
         if (!enable_ff && req_action < fenrs_pkg::ACT_RESET) begin
            status_in = fenrs_pkg::STATUS_DISABLED;
         end else if (req_action == fenrs_pkg::ACT_ENQUEUE) begin
            if (req_record_fence == 64'd0) begin
               status_in = fenrs_pkg::STATUS_NO_FENCE;
            end else if (count_ff >= CntW'(Depth)) begin
               status_in = fenrs_pkg::STATUS_FULL;
            end else begin
               enq_ok_in = 1'b1;
            end
         end
      end
      if (state_ff == fenrs_pkg::S_SCAN) step_in = step_ff + 1'b1;
      if (scan_end) begin
         rcnt_in = '0;
         if (enq_ok_ff) begin
            count_in = count_ff + 1'b1;
            seq_in   = seq_ff + 32'd1;
         end
         if (status_ff == fenrs_pkg::STATUS_OK) begin
            case (action_ff)
               fenrs_pkg::ACT_CLEAR: seq_in = seq_ff + 32'd1;
               fenrs_pkg::ACT_COMPLETE: begin
                  count_in = count_ff - scan_res.pops;
                  rcnt_in  = scan_res.pops;
                  left_in  = scan_res.pops;
                  multi_in = scan_res.pops != '0;
               end
               fenrs_pkg::ACT_RESET: begin
                  rcnt_in  = count_ff;
                  count_in = '0;
                  gen_in   = gen_ff + 32'd1;
               end
               default: rcnt_in = '0;
            endcase
         end
      end
      if (out_load && multi_ff) left_in = left_ff - 1'b1;
   end

   // result word
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_o_in  = status_o_ff;
      pseq_in      = pseq_ff;
      paddr_in     = paddr_ff;
      pfence_in    = pfence_ff;
      pgen_in      = pgen_ff;
      reqf_in      = reqf_ff;
      ovl_in       = ovl_ff;
      rc_in        = rc_ff;
      pend_in      = pend_ff;
      last_in      = last_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         status_o_in  = status_ff;
         pseq_in      = multi_ff ? cell_q[0].sequence_num : 32'd0;
         paddr_in     = multi_ff ? cell_q[0].address : 32'd0;
         pfence_in    = multi_ff ? cell_q[0].fence : 64'd0;
         pgen_in      = multi_ff ? cell_q[0].generation : 32'd0;
         reqf_in      = (action_ff == fenrs_pkg::ACT_CONSUME
                         && status_ff == fenrs_pkg::STATUS_OK) ? scan_res.required : 64'd0;
         ovl_in       = enq_ok_ff ? scan_res.overlaps : '0;
         rc_in        = rcnt_ff;
         pend_in      = count_ff;
         last_in      = !multi_ff || (left_ff == CntW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fenrs_pkg::S_IDLE;
         step_ff      <= '0;
         enq_ok_ff    <= 1'b0;
         multi_ff     <= 1'b0;
         count_ff     <= '0;
         left_ff      <= '0;
         seq_ff       <= 32'd1;
         gen_ff       <= 32'd1;
         enable_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         enq_ok_ff    <= enq_ok_in;
         multi_ff     <= multi_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         seq_ff       <= seq_in;
         gen_ff       <= gen_in;
         enable_ff    <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      addr_ff     <= addr_in;
      size_ff     <= size_in;
      rfence_ff   <= rfence_in;
      dfence_ff   <= dfence_in;
      status_ff   <= status_in;
      rcnt_ff     <= rcnt_in;
      status_o_ff <= status_o_in;
      pseq_ff     <= pseq_in;
      paddr_ff    <= paddr_in;
      pfence_ff   <= pfence_in;
      pgen_ff     <= pgen_in;
      reqf_ff     <= reqf_in;
      ovl_ff      <= ovl_in;
      rc_ff       <= rc_in;
      pend_ff     <= pend_in;
      last_ff     <= last_in;
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_status               = status_o_ff;
   assign rsp_published_sequence   = pseq_ff;
   assign rsp_published_address    = paddr_ff;
   assign rsp_published_fence      = pfence_ff;
   assign rsp_published_generation = pgen_ff;
   assign rsp_required_fence       = reqf_ff;
   assign rsp_overlap_count        = ovl_ff;
   assign rsp_result_count         = rc_ff;
   assign rsp_pending_count        = pend_ff;
   assign rsp_last                 = last_ff;

   `FRS_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CntW'(Depth), "queue count over depth")
   `FRS_ASSERT_IMPLY(a_pops_bound, clock, reset, scan_end, scan_res.pops <= count_ff, "pops exceed pending")
   `FRS_ASSERT_IMPLY(a_multi_left, clock, reset, state_ff == fenrs_pkg::S_EMIT && multi_ff, left_ff != '0, "publish with nothing left")

endmodule

>>> tb/tb.sv
// self-checking testbench of the fenced report scoreboard
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [2:0]  action;
      logic [31:0] address;
      logic [31:0] size;
      logic [63:0] rfence;
      logic [63:0] sfence;
      logic [63:0] dfence;
   } action_word_type;

   typedef struct {
      logic [1:0]  status;
      logic [31:0] pseq;
      logic [31:0] paddr;
      logic [63:0] pfence;
      logic [31:0] pgen;
      logic [63:0] required;
      logic [4:0]  overlaps;
      logic [4:0]  rcount;
      logic [4:0]  pending;
      logic        last;
   } result_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_action = '0;
   logic [31:0] req_report_address = '0;
   logic [31:0] req_read_size = '0;
   logic [63:0] req_record_fence = '0;
   logic [63:0] req_submit_fence = '0;
   logic [63:0] req_done_fence = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_published_sequence;
   logic [31:0] rsp_published_address;
   logic [63:0] rsp_published_fence;
   logic [31:0] rsp_published_generation;
   logic [63:0] rsp_required_fence;
   logic [4:0]  rsp_overlap_count;
   logic [4:0]  rsp_result_count;
   logic [4:0]  rsp_pending_count;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_enable = 1'b0;

   fenced_report_scoreboard_top dut (.*);

   always #2 clock = ~clock;

   // scoreboard shadow state
   logic [31:0] sh_addr [fenrs_pkg::QueueDepth];
   logic [63:0] sh_fence [fenrs_pkg::QueueDepth];
   logic [31:0] sh_seq [fenrs_pkg::QueueDepth];
   logic [31:0] sh_gen [fenrs_pkg::QueueDepth];
   logic [3:0]  sh_head;
   int          sh_pending;
   logic [31:0] sh_next_seq;
   logic [31:0] sh_generation;
   logic        sh_enable;

   action_word_type pending_words[$];
   result_word_type expected_results[$];
   int  errors = 0;
   bit  quiet = 1'b0;
   bit  hold_off = 1'b0;
   bit  req_taken = 1'b0;
   int  req_gap = 0;
   int  rsp_gap = 0;

   function automatic bit windows_hit(logic [31:0] a, logic [63:0] an,
                                      logic [31:0] b, logic [63:0] bn);
      logic [63:0] ae, be;
      if (an == 0 || bn == 0) return 1'b0;
      ae = {32'd0, a} + an;
      be = {32'd0, b} + bn;
      return ({32'd0, a} < be) && ({32'd0, b} < ae);
   endfunction

   function automatic void predict_results(action_word_type w);
      result_word_type r, pops[$];
      logic [63:0] req;
      logic [3:0] s;
      int ov;
      r = '{default: '0};
      case (w.action)
         fenrs_pkg::ACT_ENQUEUE: begin
            if (!sh_enable) r.status = fenrs_pkg::STATUS_DISABLED;
            else if (w.rfence == 0) r.status = fenrs_pkg::STATUS_NO_FENCE;
            else if (sh_pending >= fenrs_pkg::QueueDepth) r.status = fenrs_pkg::STATUS_FULL;
            else begin
               ov = 0;
               for (int i = 0; i < sh_pending; i++)
                  if (windows_hit(sh_addr[4'(sh_head + i)], 64'(fenrs_pkg::WindowBytes),
                                  w.address, 64'(fenrs_pkg::WindowBytes))) ov++;
               s = 4'(sh_head + sh_pending);
               sh_addr[s] = w.address;
               sh_fence[s] = w.rfence;
               sh_seq[s] = sh_next_seq;
               sh_gen[s] = sh_generation;
               sh_next_seq++;
               sh_pending++;
               r.overlaps = 5'(ov);
            end
         end
         fenrs_pkg::ACT_CLEAR: begin
            if (!sh_enable) r.status = fenrs_pkg::STATUS_DISABLED;
            else sh_next_seq++;
         end
         fenrs_pkg::ACT_COMPLETE: begin
            if (!sh_enable) r.status = fenrs_pkg::STATUS_DISABLED;
            else begin
               while (sh_pending > 0 && pops.size() < 16 && sh_fence[sh_head] <= w.dfence)
               begin
                  result_word_type p;
                  p = '{default: '0};
                  p.pseq = sh_seq[sh_head];
                  p.paddr = sh_addr[sh_head];
                  p.pfence = sh_fence[sh_head];
                  p.pgen = sh_gen[sh_head];
                  pops.push_back(p);
                  sh_head++;
                  sh_pending--;
               end
            end
         end
         fenrs_pkg::ACT_CONSUME: begin
            if (!sh_enable) r.status = fenrs_pkg::STATUS_DISABLED;
            else if (w.size != 0) begin
               req = 0;
               for (int i = 0; i < sh_pending; i++) begin
                  s = 4'(sh_head + i);
                  if (windows_hit(sh_addr[s], 64'(fenrs_pkg::WindowBytes), w.address,
                                  {32'd0, w.size})
                      && sh_fence[s] > req) req = sh_fence[s];
               end
               r.required = req;
            end
         end
         fenrs_pkg::ACT_RESET: begin
            r.rcount = 5'(sh_pending);
            sh_head = 4'(sh_head + sh_pending);
            sh_pending = 0;
            sh_generation++;
         end
         default: ;
      endcase
      if (pops.size() == 0) pops.push_back(r);
      else foreach (pops[k]) pops[k].rcount = 5'(pops.size());
      foreach (pops[k]) begin
         pops[k].pending = 5'(sh_pending);
         pops[k].last = (k == pops.size() - 1);
         expected_results.push_back(pops[k]);
      end
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         // a word still waiting holds its payload
         if (!req_valid || req_taken) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
               req_gap <= $urandom_range(0, 3);
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0 && !hold_off) begin
               action_word_type w;
               w = pending_words.pop_front();
               req_valid <= 1'b1;
               req_action <= w.action;
               req_report_address <= w.address;
               req_read_size <= w.size;
               req_record_fence <= w.rfence;
               req_submit_fence <= w.sfence;
               req_done_fence <= w.dfence;
            end else req_valid <= 1'b0;
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_gap <= $urandom_range(0, 3);
            rsp_stall <= 1'b1;
         end else rsp_stall <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            action_word_type w;
            w.action = req_action;
            w.address = req_report_address;
            w.size = req_read_size;
            w.rfence = req_record_fence;
            w.sfence = req_submit_fence;
            w.dfence = req_done_fence;
            predict_results(w);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result word");
               errors++;
            end else begin
               result_word_type e;
               e = expected_results.pop_front();
               if (rsp_status !== e.status) begin
                  $error("status exp %0d got %0d", e.status, rsp_status); errors++; end
               if (rsp_published_sequence !== e.pseq) begin
                  $error("published_sequence exp %0h got %0h", e.pseq,
                         rsp_published_sequence); errors++; end
               if (rsp_published_address !== e.paddr) begin
                  $error("published_address exp %0h got %0h", e.paddr,
                         rsp_published_address); errors++; end
               if (rsp_published_fence !== e.pfence) begin
                  $error("published_fence exp %0h got %0h", e.pfence,
                         rsp_published_fence); errors++; end
               if (rsp_published_generation !== e.pgen) begin
                  $error("published_generation exp %0h got %0h", e.pgen,
                         rsp_published_generation); errors++; end
               if (rsp_required_fence !== e.required) begin
                  $error("required_fence exp %0h got %0h", e.required,
                         rsp_required_fence); errors++; end
               if (rsp_overlap_count !== e.overlaps) begin
                  $error("overlap_count exp %0d got %0d", e.overlaps,
                         rsp_overlap_count); errors++; end
               if (rsp_result_count !== e.rcount) begin
                  $error("result_count exp %0d got %0d", e.rcount,
                         rsp_result_count); errors++; end
               if (rsp_pending_count !== e.pending) begin
                  $error("pending_count exp %0d got %0d", e.pending,
                         rsp_pending_count); errors++; end
               if (rsp_last !== e.last) begin
                  $error("last exp %0d got %0d", e.last, rsp_last); errors++; end
            end
         end
      end
   end

   function automatic logic [63:0] rand_fence();
      case ($urandom_range(0, 5))
         0: return 64'd0;
         1: return '1;
         2: return {$urandom, $urandom};
         default: return 64'($urandom_range(1, 60));
      endcase
   endfunction

   function automatic action_word_type rand_word();
      action_word_type w;
      int pick;
      pick = $urandom_range(0, 99);
      w.action = pick < 40 ? fenrs_pkg::ACT_ENQUEUE : pick < 46 ? fenrs_pkg::ACT_CLEAR :
                 pick < 70 ? fenrs_pkg::ACT_COMPLETE : pick < 90 ? fenrs_pkg::ACT_CONSUME :
                 pick < 96 ? fenrs_pkg::ACT_RESET : 3'($urandom_range(5, 7));
      w.address = $urandom_range(0, 3) == 0 ? $urandom : 32'h1000 + $urandom_range(0, 96);
      if ($urandom_range(0, 9) == 0) w.address = 32'hFFFF_FFF8;
      w.size = $urandom_range(0, 5) == 0 ? $urandom : 32'($urandom_range(0, 64));
      w.rfence = rand_fence();
      w.sfence = rand_fence();
      w.dfence = rand_fence();
      return w;
   endfunction

   task automatic push(logic [2:0] a, logic [31:0] ad, logic [31:0] sz,
                       logic [63:0] rf, logic [63:0] df);
      pending_words.push_back('{a, ad, sz, rf, df, df});
   endtask

   task automatic drain_and_write(logic en);
      wait (pending_words.size() == 0);
      @(posedge clock);
      while (expected_results.size() != 0 || req_valid || req_stall) @(posedge clock);
      repeat (40) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_enable <= en;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sh_enable = en;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      sh_head = 0;
      sh_pending = 0;
      sh_next_seq = 1;
      sh_generation = 1;
      sh_enable = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // disabled phase
      for (int a = 0; a < 8; a++) push(3'(a), 32'h10, 32'd8, 64'd5, 64'd9);
      drain_and_write(1'b1);
      push(fenrs_pkg::ACT_ENQUEUE, 32'h0, 32'd0, 64'd0, 64'd0);
      push(fenrs_pkg::ACT_ENQUEUE, 32'hFFFF_FFFF, 32'd0, '1, 64'd0);
      for (int i = 0; i < 16; i++)
         push(fenrs_pkg::ACT_ENQUEUE, 32'(32'h100 + 8 * i), 32'd0, 64'(i + 1), 64'd0);
      push(fenrs_pkg::ACT_CONSUME, 32'h100, 32'd0, 64'd0, 64'd0);
      push(fenrs_pkg::ACT_CONSUME, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 64'd0, 64'd0);
      push(fenrs_pkg::ACT_CLEAR, 32'd0, 32'd0, 64'd0, 64'd0);
      push(fenrs_pkg::ACT_COMPLETE, 32'd0, 32'd0, 64'd0, '1);
      push(fenrs_pkg::ACT_COMPLETE, 32'd0, 32'd0, 64'd0, 64'd0);
      push(fenrs_pkg::ACT_RESET, 32'd0, 32'd0, 64'd0, 64'd0);
      push(3'd7, 32'd0, 32'd0, 64'd0, 64'd0);
      wait (pending_words.size() == 0);
      hold_off = 1'b1;
      while (expected_results.size() != 0 || req_stall) @(posedge clock);
      hold_off = 1'b0;
      for (int i = 0; i < 200; i++) pending_words.push_back(rand_word());
      drain_and_write(1'b0);
      for (int i = 0; i < 20; i++) pending_words.push_back(rand_word());
      drain_and_write(1'b1);
      for (int i = 0; i < 140; i++) pending_words.push_back(rand_word());
      wait (pending_words.size() == 0);
      quiet = 1'b1;
      for (int i = 0; i < 50; i++) pending_words.push_back(rand_word());
      wait (pending_words.size() == 0);
      @(posedge clock);
      while (expected_results.size() != 0 || req_valid) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #2ms;
      $display("Regression FAIL");
      $finish;
   end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/fenrs_pkg.sv
rtl/core/fenrs_cell.sv
rtl/core/fenrs_scan.sv
rtl/core/fenced_report_scoreboard_top.sv
tb/tb.sv
